[sv/sps_pkg.sv]
// Shared types and constants for the strided prefix-sum query block.
// Holds the field widths, the mode codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package sps_pkg;

  // Fixed widths of the item fields.
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 10;
  localparam int STRIDE_W = 4;
  localparam int SUM_W    = 42;
  localparam int STEP_W   = $clog2(IDX_W);

  // Item mode codes.
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Address source for the chain bank read ports.
  typedef enum logic [1:0] {
    RD_APPEND,
    RD_RIGHT,
    RD_FIRST
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    logic    app_write;
    logic    clear_count;
    logic    mod_start;
    logic    mod_step;
    logic    cap_right;
    logic    cap_diff;
    logic    out_load;
    logic    out_err;
  } sps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              q_err;
    logic              mod_last;
    logic              out_free;
  } sps_stat_t;

endpackage

[sv/strided_prefix_sum_query.sv]
// Strided prefix-sum query engine. An append item stores a signed value and
// updates one running chain sum per stride; a query item returns the sum of
// every stride-th element from left to right, ending at right; a clear item
// empties the store. A new item waits until the last is done. An append is
// dispatched, then written; a clear or unused mode ends at dispatch; a query
// is dispatched, steps the bit-serial remainder unit that finds the first
// element, then makes two reads on the chain bank's single read port and a
// final add; a query that reports an error goes from dispatch to an error
// state. A finished result waits in an output register, so the next item is
// taken while it is unread; a second result waits until the first is taken.
// Depends on sps_pkg, sps_ctrl and sps_datapath.
`timescale 1ns / 1ps

module strided_prefix_sum_query #(
  parameter int MAX_STRIDE = 10,
  parameter int DEPTH      = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sps_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [sps_pkg::VALUE_W-1:0] value_i,
  input  logic [sps_pkg::IDX_W-1:0]          left_index_i,
  input  logic [sps_pkg::IDX_W-1:0]          right_index_i,
  input  logic [sps_pkg::STRIDE_W-1:0]       stride_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [sps_pkg::SUM_W-1:0]   range_sum_o,
  output logic                               query_error_o
);

  sps_pkg::sps_cmd_t  cmd;
  sps_pkg::sps_stat_t stat;

  // Controller.
  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  sps_datapath #(
    .MAX_STRIDE (MAX_STRIDE),
    .DEPTH      (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .stride_i      (stride_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .range_sum_o   (range_sum_o),
    .query_error_o (query_error_o)
  );

endmodule

[sv/sps_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sps_ctrl.sv]
// Controller state machine for the strided prefix-sum query block.
// Depends on sps_pkg for the command and status structs and the mode codes.
`timescale 1ns / 1ps

module sps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sps_pkg::sps_stat_t stat_i,
  output sps_pkg::sps_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_APP_WRITE,
    S_MOD,
    S_RD_FIRST,
    S_DIFF,
    S_RESULT,
    S_ERROR
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.rd_sel      = sps_pkg::RD_RIGHT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.mode)
          sps_pkg::MODE_APPEND: begin
            cmd_o.rd_sel = sps_pkg::RD_APPEND;
            state_d      = stat_i.full ? S_IDLE : S_APP_WRITE;
          end
          sps_pkg::MODE_QUERY: begin
            if (stat_i.q_err) begin
              state_d = S_ERROR;
            end else begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_MOD;
            end
          end
          sps_pkg::MODE_CLEAR: begin
            cmd_o.clear_count = 1'b1;
            state_d           = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_APP_WRITE: begin
        cmd_o.app_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        cmd_o.rd_sel    = sps_pkg::RD_FIRST;
        cmd_o.cap_right = 1'b1;
        state_d         = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.rd_sel   = sps_pkg::RD_FIRST;
        cmd_o.cap_diff = 1'b1;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.rd_sel = sps_pkg::RD_FIRST;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_ERROR: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded while output register is occupied");

  // An append never writes into a full store.
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.app_write |-> !stat_i.full)
    else $error("append written into a full store");

  // An accepted item is always dispatched in the following cycle.
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DISPATCH))
    else $error("accepted item was not dispatched");

endmodule

[sv/sps_datapath.sv]
// Datapath for the strided prefix-sum query block: item registers, element
// store, one chain-sum RAM per stride, the bit-serial remainder unit and the
// output register. Depends on sps_pkg and sps_ram.
`timescale 1ns / 1ps

module sps_datapath #(
  parameter int MAX_STRIDE = 10,
  parameter int DEPTH      = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sps_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [sps_pkg::VALUE_W-1:0]  value_i,
  input  logic [sps_pkg::IDX_W-1:0]           left_index_i,
  input  logic [sps_pkg::IDX_W-1:0]           right_index_i,
  input  logic [sps_pkg::STRIDE_W-1:0]        stride_i,
  input  sps_pkg::sps_cmd_t                   cmd_i,
  output sps_pkg::sps_stat_t                  stat_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sps_pkg::SUM_W-1:0]    range_sum_o,
  output logic                                query_error_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Captured item fields.
  logic [sps_pkg::MODE_W-1:0]   mode_q;
  logic [sps_pkg::VALUE_W-1:0]  value_q;
  logic [sps_pkg::IDX_W-1:0]    left_q;
  logic [sps_pkg::IDX_W-1:0]    right_q;
  logic [sps_pkg::STRIDE_W-1:0] stride_q;

  // Store fill count.
  logic [CW-1:0] count_q;

  // Remainder unit.
  logic [sps_pkg::STRIDE_W-1:0] rem_q, rem_d;
  logic [sps_pkg::IDX_W-1:0]    bits_q;
  logic [sps_pkg::STEP_W-1:0]   step_q;
  logic [sps_pkg::STRIDE_W:0]   rem_shift;

  // Query sum path.
  logic [sps_pkg::SUM_W-1:0] chain_right_q;
  logic [sps_pkg::SUM_W-1:0] diff_q;
  logic [sps_pkg::SUM_W-1:0] chain_sel;
  logic [sps_pkg::SUM_W-1:0] value_ext;
  logic [sps_pkg::SUM_W-1:0] elem_ext;
  logic [sps_pkg::SUM_W-1:0] sum_full;
  logic [sps_pkg::IDX_W-1:0] first_idx;
  logic [AW-1:0]             first_addr;
  logic [AW-1:0]             right_addr;
  logic [AW-1:0]             wr_addr;
  logic [sps_pkg::VALUE_W-1:0] elem_rdata;

  // Output register.
  logic                      out_valid_q;
  logic [sps_pkg::SUM_W-1:0] out_sum_q;
  logic                      out_err_q;

  logic [sps_pkg::SUM_W-1:0] bank_rdata [MAX_STRIDE];

  // Addresses and extended operands.
  assign first_idx  = left_q + sps_pkg::IDX_W'(rem_q);
  assign first_addr = AW'(first_idx);
  assign right_addr = AW'(right_q);
  assign wr_addr    = AW'(count_q);
  assign value_ext  = {{(sps_pkg::SUM_W - sps_pkg::VALUE_W){value_q[sps_pkg::VALUE_W-1]}},
                       value_q};
  assign elem_ext   = {{(sps_pkg::SUM_W - sps_pkg::VALUE_W){elem_rdata[sps_pkg::VALUE_W-1]}},
                       elem_rdata};
  assign sum_full   = diff_q + elem_ext;

  // One remainder step: shift in the next dividend bit, subtract the stride if it fits.
  assign rem_shift = {rem_q, bits_q[sps_pkg::IDX_W-1]};
  always_comb begin
    if (rem_shift >= {1'b0, stride_q}) begin
      rem_d = sps_pkg::STRIDE_W'(rem_shift - {1'b0, stride_q});
    end else begin
      rem_d = sps_pkg::STRIDE_W'(rem_shift);
    end
  end

  // Element store, read at the first selected element of a query.
  sps_ram #(
    .WIDTH (sps_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.app_write),
    .waddr_i (wr_addr),
    .wdata_i (value_q),
    .raddr_i (first_addr),
    .rdata_o (elem_rdata)
  );

  // One chain-sum bank per stride; an append updates all banks together.
  for (genvar k = 0; k < MAX_STRIDE; k++) begin : g_bank
    logic [AW-1:0]             raddr;
    logic [sps_pkg::SUM_W-1:0] prev;
    logic [sps_pkg::SUM_W-1:0] wdata;

    always_comb begin
      case (cmd_i.rd_sel)
        sps_pkg::RD_APPEND: raddr = AW'(32'(count_q) - 32'(k + 1));
        sps_pkg::RD_RIGHT:  raddr = right_addr;
        default:            raddr = first_addr;
      endcase
    end

    assign prev  = (32'(count_q) >= 32'(k + 1)) ? bank_rdata[k] : '0;
    assign wdata = prev + value_ext;

    sps_ram #(
      .WIDTH (sps_pkg::SUM_W),
      .DEPTH (DEPTH)
    ) u_chain_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.app_write),
      .waddr_i (wr_addr),
      .wdata_i (wdata),
      .raddr_i (raddr),
      .rdata_o (bank_rdata[k])
    );
  end

  // Pick the bank of the query's stride.
  always_comb begin
    chain_sel = '0;
    for (int k = 0; k < MAX_STRIDE; k++) begin
      if ({2'b00, stride_q} == 6'(k + 1)) begin
        chain_sel = chain_sel | bank_rdata[k];
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.full     = (count_q == CW'(DEPTH));
    stat_o.q_err    = (stride_q == '0) || (32'(stride_q) > MAX_STRIDE) ||
                      (32'(right_q) >= 32'(count_q)) || (left_q > right_q);
    stat_o.mod_last = (step_q == '0);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  // Control registers: fill count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_count) begin
        count_q <= '0;
      end else if (cmd_i.app_write) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      value_q  <= value_i;
      left_q   <= left_index_i;
      right_q  <= right_index_i;
      stride_q <= stride_i;
    end
    if (cmd_i.mod_start) begin
      rem_q  <= '0;
      bits_q <= right_q - left_q;
      step_q <= sps_pkg::STEP_W'(sps_pkg::IDX_W - 1);
    end else if (cmd_i.mod_step) begin
      rem_q  <= rem_d;
      bits_q <= {bits_q[sps_pkg::IDX_W-2:0], 1'b0};
      step_q <= step_q - sps_pkg::STEP_W'(1);
    end
    if (cmd_i.cap_right) begin
      chain_right_q <= chain_sel;
    end
    if (cmd_i.cap_diff) begin
      diff_q <= chain_right_q - chain_sel;
    end
    if (cmd_i.out_load) begin
      out_sum_q <= cmd_i.out_err ? '0 : sum_full;
      out_err_q <= cmd_i.out_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign range_sum_o   = out_sum_q;
  assign query_error_o = out_err_q;

  // Each append advances the fill count by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.app_write |=> (count_q == $past(count_q) + CW'(1)))
    else $error("fill count did not advance on append");

  // A flagged result always carries a zero sum.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_sum_q == '0))
    else $error("error result with nonzero sum");

endmodule
